// ===== hw/rtl/mifd_pkg.sv =====
// Package: shared types and codes for the MQTT integer field decoder.
`default_nettype none
package mifd_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned MaxBytes   = 4;
   localparam int unsigned VbiBits    = 7;

   localparam logic [7:0] VbiGroupMask = 8'h7f;
   localparam logic [7:0] VbiMoreFlag  = 8'h80;

   typedef enum logic [1:0] {
      CMD_FEED      = 2'd0,
      CMD_START_VBI = 2'd1,
      CMD_START_TWO = 2'd2,
      CMD_START_FOUR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_MORE   = 2'd0,
      ST_DONE   = 2'd1,
      ST_FORMAT = 2'd2,
      ST_CLOSED = 2'd3
   } status_type;

   typedef struct packed {
      status_type              status;
      logic [ValueWidth-1:0]   field_value;
      logic [CountWidth-1:0]   bytes_used;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mifd_core.sv =====
// Decode state and per-byte next-state and result logic.
`default_nettype none
module mifd_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire mifd_pkg::cmd_type     cmd,
   input  wire logic [7:0]            data_byte,
   output mifd_pkg::rsp_type          rsp
);

   logic                                 mode_ff, mode_in;
   logic [mifd_pkg::ValueWidth-1:0]      acc_ff, acc_in;
   logic [mifd_pkg::CountWidth-1:0]      used_ff, used_in;
   logic [mifd_pkg::CountWidth-1:0]      left_ff, left_in;
   logic [mifd_pkg::ValueWidth-1:0]      group;
   logic [mifd_pkg::CountWidth-1:0]      left_dec;
   logic                                 open;
   mifd_pkg::status_type                 status;

   always_comb begin
      group = {{(mifd_pkg::ValueWidth-8){1'b0}}, data_byte & mifd_pkg::VbiGroupMask};
      case (used_ff[1:0])
         2'd0:    group = group;
         2'd1:    group = group << mifd_pkg::VbiBits;
         2'd2:    group = group << (2 * mifd_pkg::VbiBits);
         default: group = group << (3 * mifd_pkg::VbiBits);
      endcase
   end

   assign left_dec = left_ff - 3'd1;
   assign open = (left_ff != 3'd0) && (left_ff <= 3'(mifd_pkg::MaxBytes))
              && (used_ff < 3'(mifd_pkg::MaxBytes));

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      used_in = used_ff;
      left_in = left_ff;
      status  = mifd_pkg::ST_MORE;
      unique case (cmd)
         mifd_pkg::CMD_START_VBI: begin
            mode_in = 1'b0;
            acc_in  = '0;
            used_in = '0;
            left_in = 3'(mifd_pkg::MaxBytes);
         end
         mifd_pkg::CMD_START_TWO: begin
            mode_in = 1'b1;
            acc_in  = '0;
            used_in = '0;
            left_in = 3'd2;
         end
         mifd_pkg::CMD_START_FOUR: begin
            mode_in = 1'b1;
            acc_in  = '0;
            used_in = '0;
            left_in = 3'(mifd_pkg::MaxBytes);
         end
         default: begin
            if (!open) begin
               status = mifd_pkg::ST_CLOSED;
            end else if (!mode_ff) begin
               acc_in  = acc_ff + group;
               used_in = used_ff + 3'd1;
               left_in = left_dec;
               if ((data_byte & mifd_pkg::VbiMoreFlag) == 8'h00) begin
                  left_in = '0;
                  status  = mifd_pkg::ST_DONE;
               end else if (left_dec == 3'd0) begin
                  status  = mifd_pkg::ST_FORMAT;
               end
            end else begin
               acc_in  = {acc_ff[mifd_pkg::ValueWidth-9:0], data_byte};
               used_in = used_ff + 3'd1;
               left_in = left_dec;
               if (left_dec == 3'd0) begin
                  status = mifd_pkg::ST_DONE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         acc_ff  <= '0;
         used_ff <= '0;
         left_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         used_ff <= used_in;
         left_ff <= left_in;
      end
   end

   assign rsp.status      = status;
   assign rsp.field_value = acc_in;
   assign rsp.bytes_used  = used_in;

endmodule
`default_nettype wire

// ===== hw/rtl/mqtt_integer_field_decoder_top.sv =====
// Top level: input register, decode core and result register.
//
// Decodes one MQTT integer field (variable-byte, two-byte or four-byte) from a byte
// stream, one byte per transfer, and returns one result per input transfer. Throughput
// is one transfer per cycle unless rsp_ready stalls the result register; each transfer
// passes the input register, the combinational decode core and the result register.
// Both advance when the result register is empty or drained; the input one also if empty.
`default_nettype none
module mqtt_integer_field_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_field_value,
   output logic [2:0]       rsp_bytes_used
);

   logic                  in_vld_ff, in_vld_in;
   logic [1:0]            in_cmd_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_vld_ff, out_vld_in;
   mifd_pkg::rsp_type     out_ff;
   mifd_pkg::rsp_type     core_rsp;
   logic                  advance;
   logic                  step;

   assign advance    = !out_vld_ff || rsp_ready;
   assign step       = advance && in_vld_ff;
   assign req_ready  = !in_vld_ff || advance;
   assign in_vld_in  = req_ready ? req_valid : in_vld_ff;
   assign out_vld_in = advance ? in_vld_ff : out_vld_ff;

   mifd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .cmd       (mifd_pkg::cmd_type'(in_cmd_ff)),
      .data_byte (in_byte_ff),
      .rsp       (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_ready && req_valid) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_data_byte;
      end
      if (step) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_field_value = out_ff.field_value;
   assign rsp_bytes_used  = out_ff.bytes_used;

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bytes_used <= 3'(mifd_pkg::MaxBytes))
      else $error("bytes used out of range");

   a_format_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mifd_pkg::ST_FORMAT) |-> rsp_bytes_used == 3'd4)
      else $error("format failure before fourth byte");

   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mifd_pkg::ST_MORE && rsp_bytes_used == 3'd0)
      |-> rsp_field_value == '0)
      else $error("opened field carries a value");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_cmd_ff) && $stable(in_byte_ff)))
      else $error("input register lost a stalled transfer");

endmodule
`default_nettype wire
